// ===== design/hhlp_pkg.sv =====
// Shared types, codes and the prefix table of the HTTP header line parser.
`default_nettype none

package hhlp_pkg;

	// Default packet buffer size in bytes
	localparam int unsigned BUFFER_BYTES_DEF = 2048;

	// Width of the offset, length and header length result fields
	localparam int unsigned OUT_W = 12;

	// Prefix table geometry
	localparam int unsigned NUM_PAT = 12;
	localparam int unsigned PAT_MAX = 27;
	localparam int unsigned OFS_W = 5;

	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_LF = 8'd10;

	typedef enum logic [2:0] {
		EV_LINE     = 3'd0,
		EV_HDR_END  = 3'd1,
		EV_BUF_END  = 3'd2,
		EV_POST     = 3'd3,
		EV_NOT_HTTP = 3'd4
	} event_t;

	typedef enum logic [1:0] {
		MSG_GET   = 2'd0,
		MSG_RESP  = 2'd1,
		MSG_POST  = 2'd2,
		MSG_OTHER = 2'd3
	} msg_t;

	typedef enum logic [1:0] {
		BODY_UNKNOWN = 2'd0,
		BODY_CLEN    = 2'd1,
		BODY_CHUNKED = 2'd2
	} body_t;

	// Field codes that steer the body kind
	localparam logic [3:0] FC_NONE    = 4'd0;
	localparam logic [3:0] FC_CLEN    = 4'd8;
	localparam logic [3:0] FC_CHUNKED = 4'd9;

	// Table entries that decide the message type
	localparam int unsigned PAT_POST = 0;
	localparam int unsigned PAT_GET  = 1;
	localparam int unsigned PAT_HTTP = 2;

	// Prefix text, right justified: char o of an entry of length L sits at byte L-1-o
	localparam logic [PAT_MAX*8-1:0] PAT_TEXT [NUM_PAT] = '{
		"POST ", "GET ", "HTTP/1.", "Host: ", "Accept-Encoding: ", "Accept: ",
		{"User", "_Agent: "}, "Content-Type: ", {"Content", "_Encoding: "},
		"Content-Length: ", "Transfer-Encoding: chunked",
		"Transfer-Encoding:  chunked"
	};

	localparam logic [OFS_W-1:0] PAT_LEN [NUM_PAT] = '{
		5'd5, 5'd4, 5'd7, 5'd6, 5'd17, 5'd8, 5'd12, 5'd14, 5'd18, 5'd16, 5'd26, 5'd27
	};

	localparam logic [3:0] PAT_CODE [NUM_PAT] = '{
		4'd0, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd9
	};

	// One result word as held in the output register
	typedef struct packed {
		event_t           event_res;
		logic [3:0]       field_code;
		logic [OUT_W-1:0] line_offset;
		logic [OUT_W-1:0] line_length;
		msg_t             message_type;
		body_t            body_kind;
		logic [OUT_W-1:0] header_length;
		logic             last_of_run;
	} res_t;

	// Fold ASCII upper case letters to lower case
	function automatic logic [7:0] lower_case(input logic [7:0] c);
		return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
	endfunction

	// Character o of table entry k, zero past its end
	function automatic logic [7:0] pat_char(input int unsigned k, input logic [OFS_W-1:0] o);
		logic [PAT_MAX*8-1:0] t;
		int unsigned l;
		t = PAT_TEXT[k];
		l = int'(PAT_LEN[k]);
		if (int'(o) < l) begin
			return t[8*(l-1-int'(o)) +: 8];
		end
		return 8'd0;
	endfunction

endpackage

`default_nettype wire

// ===== design/hhlp_byte_if.sv =====
// Input channel: one payload byte per word with its end of buffer mark.
`default_nettype none

interface hhlp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== design/hhlp_res_if.sv =====
// Result channel: one parser event per word.
`default_nettype none

interface hhlp_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [3:0]  field_code;
	logic [11:0] line_offset;
	logic [11:0] line_length;
	logic [1:0]  message_type;
	logic [1:0]  body_kind;
	logic [11:0] header_length;
	logic        last_of_run;

	modport source (
		output valid, output event_res, output field_code, output line_offset,
		output line_length, output message_type, output body_kind,
		output header_length, output last_of_run, input ready
	);
	modport sink (
		input valid, input event_res, input field_code, input line_offset,
		input line_length, input message_type, input body_kind,
		input header_length, input last_of_run, output ready
	);
endinterface

`default_nettype wire

// ===== design/http_header_line_parser.sv =====
// Top level of the HTTP header line parser.
`default_nettype none

// Takes one payload byte per cycle and keeps up with one byte every cycle while the
// result channel does not stall. A byte is registered at the input, scanned there by
// the parallel prefix compare and the line and message state logic, and its results
// go to the output register as the byte leaves the input stage. Most bytes give no
// result or one; a byte that both closes a recognized line and ends the buffer gives
// two, which the output register hands out one after the other while the input holds.
// After the last byte of a buffer all parsing state returns to its reset value, so the
// next buffer may follow in the very next cycle. Positions count up to BUFFER_BYTES and
// then stay there; offsets and lengths are reported in their low 12 bits.
module http_header_line_parser #(
	parameter int unsigned BUFFER_BYTES = hhlp_pkg::BUFFER_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	hhlp_byte_if.sink  bytes,
	hhlp_res_if.source results
);

	localparam int unsigned POS_W = $clog2(BUFFER_BYTES + 1);
	localparam int unsigned OW    = hhlp_pkg::OUT_W;
	localparam int unsigned NP    = hhlp_pkg::NUM_PAT;
	localparam int unsigned OFS_W = hhlp_pkg::OFS_W;
	localparam logic [POS_W-1:0] POS_BUF = POS_W'(BUFFER_BYTES);

	// Input stage
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	// Parsing state
	logic [POS_W-1:0]      pos_q;
	logic [POS_W-1:0]      lstart_q;
	logic                  cr_q;
	logic [NP-1:0]         alive_q;
	hhlp_pkg::msg_t        kind_q;
	logic                  first_q;
	hhlp_pkg::body_t       body_q;
	logic                  fin_q;

	// Output register: up to two words, pend_q still to deliver
	hhlp_pkg::res_t res0_q;
	hhlp_pkg::res_t res1_q;
	logic [1:0]     pend_q;

	logic load;
	logic pop;

	// Next state and results of the byte in the input stage
	logic [POS_W-1:0] n_pos;
	logic [POS_W-1:0] n_lstart;
	logic             n_cr;
	logic [NP-1:0]    n_alive;
	hhlp_pkg::msg_t   n_kind;
	logic             n_first;
	hhlp_pkg::body_t  n_body;
	logic             n_fin;
	hhlp_pkg::res_t   res_a;
	hhlp_pkg::res_t   res_b;
	logic             a_v;
	logic             b_v;

	logic [POS_W-1:0] offs;
	logic [POS_W-1:0] llen;
	logic             near;
	logic             active;
	logic             crlf;
	logic [NP-1:0]    alive_nx;
	logic             hit;
	logic [3:0]       hcode;

	// Handshake: take a new byte whenever the input stage empties this cycle
	assign pop   = results.valid && results.ready;
	assign load  = valid_s1 && ((pend_q == 2'd0) || ((pend_q == 2'd1) && results.ready));
	assign bytes.ready = !valid_s1 || load;

	assign offs   = pos_q - lstart_q;
	assign llen   = offs - POS_W'(1);
	assign near   = (offs >> OFS_W) == '0;
	assign active = !fin_q && (pos_q != POS_BUF);
	assign crlf   = cr_q && (data_s1 == hhlp_pkg::CH_LF);

	hhlp_prefix_match u_match (
		.alive      (alive_q),
		.offset     (offs[OFS_W-1:0]),
		.near       (near),
		.data       (data_s1),
		.alive_next (alive_nx)
	);

	// Pick the first table entry, after the POST entry, that a closed line matches
	always_comb begin
		hit   = 1'b0;
		hcode = hhlp_pkg::FC_NONE;
		for (int k = NP - 1; k >= 1; k--) begin
			if (alive_q[k] && (llen >= POS_W'(hhlp_pkg::PAT_LEN[k]))) begin
				hit   = 1'b1;
				hcode = hhlp_pkg::PAT_CODE[k];
			end
		end
	end

	// Advance the line and message state and build the results of one byte
	always_comb begin
		n_pos    = pos_q;
		n_lstart = lstart_q;
		n_cr     = cr_q;
		n_alive  = alive_q;
		n_kind   = kind_q;
		n_first  = first_q;
		n_body   = body_q;
		n_fin    = fin_q;
		res_a    = '0;
		res_b    = '0;
		a_v      = 1'b0;
		b_v      = 1'b0;

		if (active) begin
			if (crlf) begin
				if (llen == '0) begin
					n_fin = 1'b1;
					a_v   = 1'b1;
					res_a.event_res     = hhlp_pkg::EV_HDR_END;
					res_a.header_length = OW'(pos_q + POS_W'(1));
				end else if (hit) begin
					if (hcode == hhlp_pkg::FC_CLEN) begin
						n_body = hhlp_pkg::BODY_CLEN;
					end else if (hcode == hhlp_pkg::FC_CHUNKED) begin
						n_body = hhlp_pkg::BODY_CHUNKED;
					end
					a_v = 1'b1;
					res_a.event_res   = hhlp_pkg::EV_LINE;
					res_a.field_code  = hcode;
					res_a.line_offset = OW'(lstart_q);
					res_a.line_length = OW'(llen);
				end
				n_lstart = pos_q + POS_W'(1);
				n_alive  = '1;
				n_cr     = 1'b0;
			end else begin
				n_alive = alive_nx;
				n_cr    = data_s1 == hhlp_pkg::CH_CR;
				if (!first_q) begin
					if (alive_nx[hhlp_pkg::PAT_POST] && (offs == POS_W'(4))) begin
						n_kind  = hhlp_pkg::MSG_POST;
						n_first = 1'b1;
						n_fin   = 1'b1;
						a_v     = 1'b1;
						res_a.event_res = hhlp_pkg::EV_POST;
					end else if (alive_nx[hhlp_pkg::PAT_GET] && (offs == POS_W'(3))) begin
						n_kind  = hhlp_pkg::MSG_GET;
						n_first = 1'b1;
					end else if (alive_nx[hhlp_pkg::PAT_HTTP] && (offs == POS_W'(6))) begin
						n_kind  = hhlp_pkg::MSG_RESP;
						n_first = 1'b1;
					end else if (alive_nx[2:0] == 3'b000) begin
						n_kind  = hhlp_pkg::MSG_OTHER;
						n_first = 1'b1;
						n_fin   = 1'b1;
						a_v     = 1'b1;
						res_a.event_res = hhlp_pkg::EV_NOT_HTTP;
					end
				end
			end
			n_pos = pos_q + POS_W'(1);
		end
		res_a.message_type = n_kind;
		res_a.body_kind    = n_body;

		// End of buffer: report it unless parsing already stopped, then return to the reset state
		if (last_s1) begin
			if (!n_fin) begin
				b_v = 1'b1;
				if (!n_first) begin
					n_kind = hhlp_pkg::MSG_OTHER;
					res_b.event_res = hhlp_pkg::EV_NOT_HTTP;
				end else begin
					res_b.event_res     = hhlp_pkg::EV_BUF_END;
					res_b.header_length = OW'(n_lstart);
				end
				res_b.message_type = n_kind;
				res_b.body_kind    = n_body;
			end
			n_pos    = '0;
			n_lstart = '0;
			n_cr     = 1'b0;
			n_alive  = '1;
			n_kind   = hhlp_pkg::MSG_OTHER;
			n_first  = 1'b0;
			n_body   = hhlp_pkg::BODY_UNKNOWN;
			n_fin    = 1'b0;
		end

		// Mark the last word of the run
		res_a.last_of_run = !b_v;
		res_b.last_of_run = 1'b1;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pos_q    <= '0;
			lstart_q <= '0;
			cr_q     <= 1'b0;
			alive_q  <= '1;
			kind_q   <= hhlp_pkg::MSG_OTHER;
			first_q  <= 1'b0;
			body_q   <= hhlp_pkg::BODY_UNKNOWN;
			fin_q    <= 1'b0;
			pend_q   <= 2'd0;
		end else begin
			if (bytes.ready) begin
				valid_s1 <= bytes.valid;
			end
			if (load) begin
				pos_q    <= n_pos;
				lstart_q <= n_lstart;
				cr_q     <= n_cr;
				alive_q  <= n_alive;
				kind_q   <= n_kind;
				first_q  <= n_first;
				body_q   <= n_body;
				fin_q    <= n_fin;
				pend_q   <= {1'b0, a_v} + {1'b0, b_v};
			end else if (pop) begin
				pend_q <= pend_q - 2'd1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			data_s1 <= bytes.data_byte;
			last_s1 <= bytes.last_byte;
		end
		if (load) begin
			res0_q <= a_v ? res_a : res_b;
			res1_q <= res_b;
		end else if (pop && (pend_q == 2'd2)) begin
			res0_q <= res1_q;
		end
	end

	// Drive the result channel from the head word
	assign results.valid         = pend_q != 2'd0;
	assign results.event_res     = res0_q.event_res;
	assign results.field_code    = res0_q.field_code;
	assign results.line_offset   = res0_q.line_offset;
	assign results.line_length   = res0_q.line_length;
	assign results.message_type  = res0_q.message_type;
	assign results.body_kind     = res0_q.body_kind;
	assign results.header_length = res0_q.header_length;
	assign results.last_of_run   = res0_q.last_of_run;

	// Positions saturate at the buffer size
	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_BUF)
		else $error("byte position beyond buffer size");

	// A line never starts past the current position
	a_line_start: assert property (@(posedge clk) disable iff (!arst_n)
		lstart_q <= pos_q)
		else $error("line start ahead of byte position");

	// The final byte of a buffer returns the parser to its start state
	a_buf_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(load && last_s1) |=> (pos_q == '0 && !fin_q && !first_q))
		else $error("parser state not cleared after last byte");

	// With two words queued the head word is not the last of its run
	a_run_order: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q == 2'd2) |-> !res0_q.last_of_run)
		else $error("run end marked on first of two words");

	// Parsing only stops once the message type is settled
	a_fin_typed: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> first_q)
		else $error("header finished before message type decided");

endmodule

`default_nettype wire

// ===== design/hhlp_prefix_match.sv =====
// Per-prefix match bits: drop each table entry whose next character differs from the byte.
`default_nettype none

module hhlp_prefix_match (
	input  wire logic [hhlp_pkg::NUM_PAT-1:0] alive,
	input  wire logic [hhlp_pkg::OFS_W-1:0]   offset,
	input  wire logic                         near,
	input  wire logic [7:0]                   data,
	output logic      [hhlp_pkg::NUM_PAT-1:0] alive_next
);

	logic [7:0] data_lc;

	assign data_lc = hhlp_pkg::lower_case(data);

	// Compare every entry in parallel, case folded, only inside its length
	for (genvar k = 0; k < hhlp_pkg::NUM_PAT; k++) begin : g_pat
		logic in_pat;
		logic differs;

		assign in_pat  = near && (offset < hhlp_pkg::PAT_LEN[k]);
		assign differs = data_lc != hhlp_pkg::lower_case(hhlp_pkg::pat_char(k, offset));
		assign alive_next[k] = alive[k] && !(in_pat && differs);
	end

endmodule

`default_nettype wire

// ===== verif/hhlp_tb_pkg.sv =====
// Line tracker for the HTTP header line parser bench: predicts and checks result words.
`timescale 1ns / 1ps

package hhlp_tb_pkg;

	import hhlp_pkg::*;

	// Field codes not named in the design package
	localparam logic [3:0] FC_REQUEST = 4'd0;
	localparam logic [3:0] FC_STATUS  = 4'd1;
	localparam logic [3:0] FC_HOST    = 4'd2;
	localparam logic [3:0] FC_ACC_ENC = 4'd3;
	localparam logic [3:0] FC_ACCEPT  = 4'd4;
	localparam logic [3:0] FC_AGENT   = 4'd5;
	localparam logic [3:0] FC_CTYPE   = 4'd6;
	localparam logic [3:0] FC_CENC    = 4'd7;

	class http_line_tracker;
		string            prefix_text [NUM_PAT];
		logic [3:0]       prefix_code [NUM_PAT];
		int unsigned      position;
		int unsigned      start_of_line;
		bit               cr_seen;
		bit               type_known;
		bit               stopped;
		bit [NUM_PAT-1:0] alive;
		msg_t             msg_kind;
		body_t            framing;
		res_t             expected_q [$];
		res_t             run_q [$];
		int unsigned      errors;
		int unsigned      taken_bytes;

		function new();
			prefix_text = '{
				"POST ", "GET ", "HTTP/1.", "Host: ", "Accept-Encoding: ", "Accept: ",
				{"User", "_Agent: "}, "Content-Type: ", {"Content", "_Encoding: "},
				"Content-Length: ", "Transfer-Encoding: chunked",
				"Transfer-Encoding:  chunked"
			};
			prefix_code = '{
				FC_REQUEST, FC_REQUEST, FC_STATUS, FC_HOST, FC_ACC_ENC, FC_ACCEPT,
				FC_AGENT, FC_CTYPE, FC_CENC, FC_CLEN, FC_CHUNKED, FC_CHUNKED
			};
			errors = 0;
			taken_bytes = 0;
			restart();
		endfunction

		// Return to the state of a fresh buffer
		function void restart();
			position = 0;
			start_of_line = 0;
			cr_seen = 1'b0;
			type_known = 1'b0;
			stopped = 1'b0;
			alive = '1;
			msg_kind = MSG_OTHER;
			framing = BODY_UNKNOWN;
		endfunction

		function logic [7:0] fold_case(logic [7:0] c);
			if (c >= "A" && c <= "Z") begin
				return c ^ 8'h20;
			end
			return c;
		endfunction

		function void post(event_t ev, logic [3:0] code, int unsigned off, int unsigned len,
				int unsigned hlen);
			res_t r;
			r = '0;
			r.event_res = ev;
			r.field_code = code;
			r.line_offset = off[OUT_W-1:0];
			r.line_length = len[OUT_W-1:0];
			r.message_type = msg_kind;
			r.body_kind = framing;
			r.header_length = hlen[OUT_W-1:0];
			r.last_of_run = 1'b0;
			run_q.push_back(r);
		endfunction

		// Note one accepted byte word and queue the result words it causes
		function void take_byte(logic [7:0] b, logic last);
			int unsigned cur;
			int unsigned o;
			int unsigned len;
			bit hit;
			run_q.delete();
			taken_bytes++;
			cur = position;
			if (!stopped && cur < BUFFER_BYTES_DEF) begin
				if (cr_seen && b == CH_LF) begin
					// close the line; the CR sits at cur-1
					len = (cur - 1 >= start_of_line) ? cur - 1 - start_of_line : 0;
					if (len == 0) begin
						stopped = 1'b1;
						post(EV_HDR_END, FC_NONE, 0, 0, cur + 1);
					end else begin
						hit = 1'b0;
						for (int k = 1; k < NUM_PAT; k++) begin
							if (!hit && alive[k] && len >= prefix_text[k].len()) begin
								hit = 1'b1;
								if (prefix_code[k] == FC_CLEN) begin
									framing = BODY_CLEN;
								end else if (prefix_code[k] == FC_CHUNKED) begin
									framing = BODY_CHUNKED;
								end
								post(EV_LINE, prefix_code[k], start_of_line, len, 0);
							end
						end
					end
					start_of_line = cur + 1;
					alive = '1;
					cr_seen = 1'b0;
				end else begin
					// drop prefixes that this byte breaks
					o = cur - start_of_line;
					for (int k = 0; k < NUM_PAT; k++) begin
						if (alive[k] && o < prefix_text[k].len()) begin
							if (fold_case(b) != fold_case(prefix_text[k][o])) begin
								alive[k] = 1'b0;
							end
						end
					end
					cr_seen = (b == CH_CR);
					if (!type_known) begin
						if (alive[PAT_POST] && o == prefix_text[PAT_POST].len() - 1) begin
							msg_kind = MSG_POST;
							type_known = 1'b1;
							stopped = 1'b1;
							post(EV_POST, FC_NONE, 0, 0, 0);
						end else if (alive[PAT_GET] && o == prefix_text[PAT_GET].len() - 1) begin
							msg_kind = MSG_GET;
							type_known = 1'b1;
						end else if (alive[PAT_HTTP] && o == prefix_text[PAT_HTTP].len() - 1) begin
							msg_kind = MSG_RESP;
							type_known = 1'b1;
						end else if (!(alive[PAT_POST] || alive[PAT_GET] || alive[PAT_HTTP])) begin
							msg_kind = MSG_OTHER;
							type_known = 1'b1;
							stopped = 1'b1;
							post(EV_NOT_HTTP, FC_NONE, 0, 0, 0);
						end
					end
				end
				position = cur + 1;
			end

			// report the end of the buffer unless parsing already stopped
			if (last) begin
				if (!stopped) begin
					if (!type_known) begin
						msg_kind = MSG_OTHER;
						post(EV_NOT_HTTP, FC_NONE, 0, 0, 0);
					end else begin
						post(EV_BUF_END, FC_NONE, 0, 0, start_of_line);
					end
				end
				restart();
			end

			if (run_q.size() > 0) begin
				run_q[run_q.size() - 1].last_of_run = 1'b1;
			end
			foreach (run_q[i]) begin
				expected_q.push_back(run_q[i]);
			end
		endfunction

		function void compare_field(string what, int unsigned want_v, int unsigned got_v);
			if (want_v != got_v) begin
				errors++;
				$display("%0t: %s expected %0d, got %0d", $time, what, want_v, got_v);
			end
		endfunction

		// Check one accepted result word against the oldest expectation
		function void check_event(res_t got);
			res_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result word with none expected, event %0d", $time,
					got.event_res);
				return;
			end
			want = expected_q.pop_front();
			compare_field("event_res", want.event_res, got.event_res);
			compare_field("field_code", want.field_code, got.field_code);
			compare_field("line_offset", want.line_offset, got.line_offset);
			compare_field("line_length", want.line_length, got.line_length);
			compare_field("message_type", want.message_type, got.message_type);
			compare_field("body_kind", want.body_kind, got.body_kind);
			compare_field("header_length", want.header_length, got.header_length);
			compare_field("last_of_run", want.last_of_run, got.last_of_run);
		endfunction
	endclass

endpackage

// ===== verif/http_header_line_parser_tb.sv =====
// Bench for the HTTP header line parser: directed and random packet buffers.
`timescale 1ns / 1ps

module http_header_line_parser_tb;

	import hhlp_pkg::*;
	import hhlp_tb_pkg::*;

	localparam int unsigned RANDOM_BYTES = 620;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned DRAIN_CYCLES = 12;

	logic clk = 1'b0;
	logic arst_n;

	hhlp_byte_if byte_ch ();
	hhlp_res_if  res_ch ();

	http_line_tracker sb;
	logic [7:0]       stream_q [$];
	res_t             got_word;
	int               src_idle = 10;
	int               snk_idle = 70;
	bit               hold_req = 1'b0;
	bit               hold_done = 1'b0;
	int unsigned      hold_cnt = 0;

	http_header_line_parser u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (byte_ch),
		.results (res_ch)
	);

	always #5 clk = ~clk;

	// Append text, optionally flipping letter case and breaking one position
	function automatic void put_text(string s, bit mixed, int bad_at);
		logic [7:0] c;
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			if (i == bad_at) begin
				c = 8'($urandom_range(255));
			end else if (mixed && $urandom_range(1) == 1 &&
					((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))) begin
				c = c ^ 8'h20;
			end
			stream_q.push_back(c);
		end
	endfunction

	function automatic void put_printable(int n);
		for (int i = 0; i < n; i++) begin
			stream_q.push_back(8'($urandom_range(32, 126)));
		end
	endfunction

	function automatic void put_random(int n);
		for (int i = 0; i < n; i++) begin
			stream_q.push_back(8'($urandom_range(255)));
		end
	endfunction

	function automatic void put_crlf();
		stream_q.push_back(CH_CR);
		stream_q.push_back(CH_LF);
	endfunction

	// Build one header line; mostly table prefixes with random case and value
	function automatic void put_header_line();
		int    sel;
		int    k;
		string p;
		sel = $urandom_range(99);
		k = $urandom_range(1, NUM_PAT - 1);
		p = sb.prefix_text[k];
		if (sel < 65) begin
			put_text(p, 1'($urandom_range(1)), -1);
			put_printable((k >= 10) ? $urandom_range(0, 2) : $urandom_range(0, 8));
		end else if (sel < 75) begin
			put_text(p.substr(0, $urandom_range(0, p.len() - 2)), 1, -1);
		end else if (sel < 85) begin
			put_text(p, 1, $urandom_range(0, p.len() - 1));
			put_printable($urandom_range(0, 4));
		end else if (sel < 92) begin
			put_printable($urandom_range(1, 20));
		end else begin
			put_random($urandom_range(1, 12));
		end
		// add a stray CR or LF inside the line now and then
		if ($urandom_range(9) == 0) begin
			case ($urandom_range(2))
				0: begin
					stream_q.push_back(CH_CR);
					stream_q.push_back("x");
				end
				1: stream_q.push_back(CH_LF);
				default: stream_q.push_back(CH_CR);
			endcase
		end
		put_crlf();
	endfunction

	// Build one whole buffer: first line, header lines, some ending
	function automatic void put_message();
		int    sel;
		int    j;
		string p;
		sel = $urandom_range(99);
		if (sel < 45) begin
			put_text("GET ", 1, -1);
			put_printable($urandom_range(0, 6));
			if ($urandom_range(1) == 1) begin
				put_text(" HTTP/1.1", 0, -1);
			end
		end else if (sel < 72) begin
			put_text("HTTP/1.", 1, -1);
			put_printable($urandom_range(0, 10));
		end else if (sel < 80) begin
			put_text("POST ", 1, -1);
			put_printable(3);
		end else if (sel < 88) begin
			put_random($urandom_range(1, 8));
		end else begin
			// stop short of a type prefix, then break or end the line
			p = sb.prefix_text[$urandom_range(PAT_HTTP)];
			j = $urandom_range(0, p.len() - 1);
			if (j > 0) begin
				put_text(p.substr(0, j - 1), 1, -1);
			end
			if ($urandom_range(1) == 1) begin
				put_crlf();
			end else begin
				put_random(1);
			end
		end
		put_crlf();
		repeat ($urandom_range(0, 6)) put_header_line();
		sel = $urandom_range(99);
		if (sel < 60) begin
			put_crlf();
			put_random($urandom_range(0, 4));
		end else if (sel < 72) begin
			// end right after a line, so its LF can carry two results when the line is recognized
		end else if (sel < 84) begin
			put_printable($urandom_range(1, 6));
		end else if (sel < 94) begin
			put_printable($urandom_range(0, 4));
			stream_q.push_back(CH_CR);
		end else begin
			put_crlf();
		end
	endfunction

	// Offer one byte word and hold it until the block takes it
	task automatic offer_byte(logic [7:0] b, logic last);
		while ($urandom_range(99) < src_idle) begin
			byte_ch.valid = 1'b0;
			@(negedge clk);
		end
		byte_ch.valid = 1'b1;
		byte_ch.data_byte = b;
		byte_ch.last_byte = last;
		@(posedge clk);
		while (!byte_ch.ready) begin
			@(posedge clk);
		end
		sb.take_byte(b, last);
		@(negedge clk);
	endtask

	task automatic send_stream();
		foreach (stream_q[i]) begin
			offer_byte(stream_q[i], i == stream_q.size() - 1);
		end
		stream_q.delete();
	endtask

	// Short buffers for type decisions, stray CR and LF, and double results
	task automatic run_directed();
		put_text("G", 0, -1);
		send_stream();
		stream_q.push_back(8'hFF);
		stream_q.push_back(8'h00);
		send_stream();
		put_text("POST /", 0, -1);
		send_stream();
		put_text("gEt a", 0, -1);
		put_crlf();
		put_crlf();
		stream_q.push_back(8'h80);
		send_stream();
		put_text("HTTP/1.0", 0, -1);
		put_crlf();
		put_text("host: ", 0, -1);
		stream_q.push_back(CH_CR);
		send_stream();
		put_text("GET ", 0, -1);
		put_crlf();
		put_text("Content-Length: 9", 0, -1);
		put_crlf();
		send_stream();
		put_text("GET /", 0, -1);
		stream_q.push_back(CH_LF);
		stream_q.push_back(CH_CR);
		stream_q.push_back("y");
		put_crlf();
		put_text("Transfer-Encoding:  chunked", 0, -1);
		put_crlf();
		put_text("accept: ", 0, -1);
		put_crlf();
		put_crlf();
		send_stream();
	endtask

	// Drive result ready: random stalls, plus one long hold-off
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				res_ch.ready = 1'b0;
				hold_cnt++;
				if (hold_cnt >= HOLD_CYCLES) begin
					hold_done = 1'b1;
				end
			end else begin
				res_ch.ready = ($urandom_range(99) >= snk_idle);
			end
		end
	end

	// Check each accepted result word
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got_word.event_res = event_t'(res_ch.event_res);
			got_word.field_code = res_ch.field_code;
			got_word.line_offset = res_ch.line_offset;
			got_word.line_length = res_ch.line_length;
			got_word.message_type = msg_t'(res_ch.message_type);
			got_word.body_kind = body_t'(res_ch.body_kind);
			got_word.header_length = res_ch.header_length;
			got_word.last_of_run = res_ch.last_of_run;
			sb.check_event(got_word);
		end
	end

	initial begin
		int unsigned base;
		int unsigned done;
		sb = new();
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = 8'd0;
		byte_ch.last_byte = 1'b0;
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();

		// random buffers over three idling phases
		base = sb.taken_bytes;
		done = 0;
		while (done < RANDOM_BYTES) begin
			if (done >= 2 * RANDOM_BYTES / 3) begin
				src_idle = 0;
				snk_idle = 0;
				hold_req = 1'b1;
			end else if (done >= RANDOM_BYTES / 3) begin
				src_idle = 70;
				snk_idle = 10;
			end
			put_message();
			send_stream();
			done = sb.taken_bytes - base;
		end
		byte_ch.valid = 1'b0;

		// wait for the outstanding words, then watch for strays
		while (sb.expected_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
